FILE: rtl/q4dp_pkg.sv
// ----------------------------------------------------------------------------
// q4dp_pkg: shared types and constants for the quantized block dot product
// Holds the controller state encoding, the command and status bundles between
// controller and datapath, and the float32 constants used by the datapath.
// ----------------------------------------------------------------------------
package q4dp_pkg;

  localparam int unsigned PAIRS_PER_BLOCK = 16;
  localparam int unsigned CNT_W = $clog2(PAIRS_PER_BLOCK);
  localparam int unsigned ACC_W = 17;
  localparam int unsigned SPROD_W = 22;
  localparam int unsigned MAG_W = 38;
  localparam int unsigned ALIGN_W = 28;
  localparam int unsigned BEXP_W = 11;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam logic [7:0] EXP_MAX = 8'hFF;
  localparam logic [4:0] HALF_EXP_MAX = 5'h1F;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL1  = 7'b0000010,
    ST_MUL2  = 7'b0000100,
    ST_NORM  = 7'b0001000,
    ST_RND   = 7'b0010000,
    ST_ADD   = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic accept;
    logic mul1;
    logic mul2;
    logic norm;
    logic rnd_term;
    logic rnd_row;
    logic align;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic eor;
    logic term_direct;
    logic norm_done;
    logic sum_direct;
    logic out_busy;
  } status_t;

endpackage

FILE: rtl/q4dp_ctrl.sv
// ----------------------------------------------------------------------------
// q4dp_ctrl: sequencer for the quantized block dot product
// Steps one closing request through the scale multiply, normalize, round and
// row add, and hands finished row sums to the output register.
// ----------------------------------------------------------------------------
module q4dp_ctrl
  import q4dp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (sts.close) begin
            state_nxt = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2 = 1'b1;
        phase_nxt = 1'b0;
        state_nxt = sts.term_direct ? ST_ADD : ST_NORM;
      end
      ST_NORM: begin
        if (sts.norm_done) begin
          state_nxt = ST_RND;
        end else begin
          cmd.norm = 1'b1;
        end
      end
      ST_RND: begin
        if (phase_r) begin
          cmd.rnd_row = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          cmd.rnd_term = 1'b1;
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.align = 1'b1;
        phase_nxt = 1'b1;
        state_nxt = sts.sum_direct ? ST_FIN : ST_NORM;
      end
      ST_FIN: begin
        if (!sts.eor) begin
          cmd.finish = 1'b1;
          state_nxt = ST_IDLE;
        end else if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          cmd.emit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

FILE: rtl/q4dp_dpath.sv
// ----------------------------------------------------------------------------
// q4dp_dpath: datapath for the quantized block dot product
// Integer block accumulator, exact scale product, term multiply, a shared
// normalizer and rounder, the float32 row adder and the output register.
// ----------------------------------------------------------------------------
module q4dp_dpath
  import q4dp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [55:0] in_tdata,
  input  logic        in_tlast,
  input  cmd_t        cmd,
  output status_t     sts,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata
);

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic eor_r;
  logic [15:0] ws_r, as_r;
  logic [SPROD_W-1:0] sprod_r;
  logic [MAG_W-1:0] mag_r;
  logic signed [BEXP_W-1:0] bexp_r;
  logic sgn_r;
  logic [31:0] term_r, row_r, dot_r;
  logic out_valid_r;

  // Input unpack and pair products.
  logic [7:0] pw;
  logic signed [7:0] a0, a1;
  logic signed [3:0] w0, w1;
  logic signed [11:0] p0, p1;
  logic signed [12:0] contrib;

  assign pw = in_tdata[7:0];
  assign a0 = in_tdata[15:8];
  assign a1 = in_tdata[23:16];
  assign w0 = {~pw[3], pw[2:0]};
  assign w1 = {~pw[7], pw[6:4]};
  assign p0 = 12'(w0) * 12'(a0);
  assign p1 = 12'(w1) * 12'(a1);
  assign contrib = 13'(p0) + 13'(p1);
  assign acc_nxt = acc_r + ACC_W'(contrib);

  // Half precision scale unpack: value = sig * 2^exp.
  logic [10:0] sw, sa;
  logic signed [5:0] ew, ea;
  logic w_spec, a_spec, w_nan, a_nan, w_zero, a_zero;

  always_comb begin
    w_spec = (ws_r[14:10] == HALF_EXP_MAX);
    a_spec = (as_r[14:10] == HALF_EXP_MAX);
    w_nan = w_spec && (ws_r[9:0] != 10'd0);
    a_nan = a_spec && (as_r[9:0] != 10'd0);
    w_zero = (ws_r[14:0] == 15'd0);
    a_zero = (as_r[14:0] == 15'd0);
    if (ws_r[14:10] == 5'd0) begin
      sw = {1'b0, ws_r[9:0]};
      ew = -6'sd24;
    end else begin
      sw = {1'b1, ws_r[9:0]};
      ew = $signed({1'b0, ws_r[14:10]}) - 6'sd25;
    end
    if (as_r[14:10] == 5'd0) begin
      sa = {1'b0, as_r[9:0]};
      ea = -6'sd24;
    end else begin
      sa = {1'b1, as_r[9:0]};
      ea = $signed({1'b0, as_r[14:10]}) - 6'sd25;
    end
  end

  // Term product and its special cases.
  logic acc_neg, acc_zero, t_sign;
  logic [ACC_W-1:0] acc_abs;
  logic [MAG_W-1:0] tprod;
  logic [31:0] term_spec;
  logic term_direct;

  assign acc_neg = acc_r[ACC_W-1];
  assign acc_zero = (acc_r == '0);
  assign acc_abs = acc_neg ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign t_sign = ws_r[15] ^ as_r[15] ^ acc_neg;
  assign tprod = MAG_W'(sprod_r) * MAG_W'(acc_abs);

  always_comb begin
    term_direct = 1'b1;
    term_spec = {t_sign, 31'd0};
    if (w_nan || a_nan) begin
      term_spec = CANON_NAN;
    end else if (w_spec || a_spec) begin
      if (w_zero || a_zero || acc_zero) begin
        term_spec = CANON_NAN;
      end else begin
        term_spec = {t_sign, EXP_MAX, 23'd0};
      end
    end else if (w_zero || a_zero || acc_zero) begin
      term_spec = {t_sign, 31'd0};
    end else begin
      term_direct = 1'b0;
    end
  end

  // Rounder: mag_r holds a normalized significand with the leading one on top.
  logic [24:0] m25;
  logic rnd_up;
  logic signed [BEXP_W-1:0] rexp;
  logic [31:0] rnd_res;

  always_comb begin
    rnd_up = mag_r[13] && ((|mag_r[12:0]) || mag_r[14]);
    m25 = {1'b0, mag_r[37:14]} + 25'(rnd_up);
    rexp = m25[24] ? bexp_r + BEXP_W'(1) : bexp_r;
    if (rexp >= BEXP_W'(255)) begin
      rnd_res = {sgn_r, EXP_MAX, 23'd0};
    end else begin
      rnd_res = {sgn_r, rexp[7:0], m25[24] ? 23'd0 : m25[22:0]};
    end
  end

  // Row adder: special cases and alignment.
  logic r_nan, t_nan, r_inf, t_inf, r_zero, t_zero;
  logic [31:0] sum_spec;
  logic sum_direct;
  logic swap;
  logic [7:0] e_big, e_sml, dexp;
  logic [23:0] s_big, s_sml;
  logic sg_big;
  logic [26:0] big27, sml27, sh27, lost;
  logic sticky;
  logic [ALIGN_W-1:0] sum28;

  always_comb begin
    r_nan = (row_r[30:23] == EXP_MAX) && (row_r[22:0] != 23'd0);
    t_nan = (term_r[30:23] == EXP_MAX) && (term_r[22:0] != 23'd0);
    r_inf = (row_r[30:23] == EXP_MAX) && (row_r[22:0] == 23'd0);
    t_inf = (term_r[30:23] == EXP_MAX) && (term_r[22:0] == 23'd0);
    r_zero = (row_r[30:23] == 8'd0);
    t_zero = (term_r[30:23] == 8'd0);

    swap = (term_r[30:23] > row_r[30:23]) ||
           ((term_r[30:23] == row_r[30:23]) && (term_r[22:0] > row_r[22:0]));
    e_big = swap ? term_r[30:23] : row_r[30:23];
    e_sml = swap ? row_r[30:23] : term_r[30:23];
    s_big = swap ? {1'b1, term_r[22:0]} : {1'b1, row_r[22:0]};
    s_sml = swap ? {1'b1, row_r[22:0]} : {1'b1, term_r[22:0]};
    sg_big = swap ? term_r[31] : row_r[31];
    dexp = e_big - e_sml;
    big27 = {s_big, 3'b000};
    sml27 = {s_sml, 3'b000};
    if (dexp >= 8'd27) begin
      sh27 = '0;
      sticky = 1'b1;
    end else begin
      sh27 = sml27 >> dexp;
      lost = sml27 & ((27'd1 << dexp) - 27'd1);
      sticky = |lost;
    end
    if (dexp < 8'd27) begin
      lost = sml27 & ((27'd1 << dexp) - 27'd1);
    end else begin
      lost = '0;
    end
    if (row_r[31] != term_r[31]) begin
      sum28 = {1'b0, big27} - {1'b0, sh27 | 27'(sticky)};
    end else begin
      sum28 = {1'b0, big27} + {1'b0, sh27 | 27'(sticky)};
    end

    sum_direct = 1'b1;
    if (r_nan || t_nan || (r_inf && t_inf && (row_r[31] != term_r[31]))) begin
      sum_spec = CANON_NAN;
    end else if (r_inf) begin
      sum_spec = row_r;
    end else if (t_inf) begin
      sum_spec = term_r;
    end else if (r_zero && t_zero) begin
      sum_spec = {row_r[31] & term_r[31], 31'd0};
    end else if (r_zero) begin
      sum_spec = term_r;
    end else if (t_zero) begin
      sum_spec = row_r;
    end else if (sum28 == '0) begin
      sum_spec = 32'd0;
    end else begin
      sum_spec = 32'd0;
      sum_direct = 1'b0;
    end
  end

  assign sts.close = (cnt_r == CNT_W'(PAIRS_PER_BLOCK - 1)) || in_tlast;
  assign sts.eor = eor_r;
  assign sts.term_direct = term_direct;
  assign sts.norm_done = mag_r[MAG_W-1];
  assign sts.sum_direct = sum_direct;
  assign sts.out_busy = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      eor_r <= 1'b0;
      row_r <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_r + CNT_W'(1);
        eor_r <= in_tlast;
      end
      if (cmd.finish) begin
        acc_r <= '0;
        cnt_r <= '0;
      end
      if (cmd.rnd_row) begin
        row_r <= rnd_res;
      end
      if (cmd.align && sum_direct) begin
        row_r <= sum_spec;
      end
      if (cmd.emit) begin
        row_r <= 32'd0;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ws_r <= in_tdata[39:24];
      as_r <= in_tdata[55:40];
    end
    if (cmd.mul1) begin
      sprod_r <= SPROD_W'(sw) * SPROD_W'(sa);
    end
    if (cmd.mul2) begin
      mag_r <= tprod;
      bexp_r <= BEXP_W'(ew) + BEXP_W'(ea) + BEXP_W'(164);
      sgn_r <= t_sign;
      if (term_direct) begin
        term_r <= term_spec;
      end
    end
    if (cmd.norm) begin
      if (mag_r[MAG_W-1 -: 8] == 8'd0) begin
        mag_r <= mag_r << 8;
        bexp_r <= bexp_r - BEXP_W'(8);
      end else begin
        mag_r <= mag_r << 1;
        bexp_r <= bexp_r - BEXP_W'(1);
      end
    end
    if (cmd.rnd_term) begin
      term_r <= rnd_res;
    end
    if (cmd.align && !sum_direct) begin
      mag_r <= {sum28, 10'd0};
      bexp_r <= BEXP_W'(e_big) + BEXP_W'(1);
      sgn_r <= sg_big;
    end
    if (cmd.emit) begin
      dot_r <= row_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = dot_r;

endmodule

FILE: rtl/quant4_block_dot_product.sv
// ----------------------------------------------------------------------------
// quant4_block_dot_product: 4-bit by 8-bit quantized block dot product
// A request that does not close a block keeps the input ready. A closing
// request holds the input through the scale multiply, the shift-by-one-or-eight
// normalizer that serves both the term multiply and the row add, and any wait
// for the output register to drain on end of row. Synchronous active-low reset
// clears the sequencer, block count, block sum, row sum and output valid.
// ----------------------------------------------------------------------------
module quant4_block_dot_product
  import q4dp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // packed_weights, act_first, act_second, weight_scale, act_scale
  input  logic [55:0] in_tdata,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // dot_result
  output logic [31:0] out_tdata
);

  cmd_t    cmd;
  status_t sts;

  q4dp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  q4dp_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: verif/tb_quant4_block_dot_product_chk.sv
// ----------------------------------------------------------------------------
// tb_quant4_block_dot_product_chk: row result checker for the q4 dot product
// Watches both stream channels. For every accepted request it updates its own
// block sum, pair count and float32 row sum, using bit-exact float32 arithmetic
// with round-to-nearest-even, and queues the row result expected on end of row.
// Every accepted result is compared with the oldest queued row result.
// ----------------------------------------------------------------------------
module tb_quant4_block_dot_product_chk
  import q4dp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  output int          errors,
  output int          dots_pending,
  output int          dots_seen,
  output int          blocks_closed
);

  logic [31:0] expected_dots[$];
  logic signed [ACC_W-1:0] block_sum;
  int unsigned pair_cnt;
  logic [31:0] row_sum;

  function automatic logic [31:0] round_f32(input logic s, input logic [63:0] mag, input int e);
    int p;
    int lsbw;
    int sh;
    int biased;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    if (mag == 0) return {s, 31'b0};
    p = 63;
    while (!mag[p]) p--;
    if (p + e > 127) return {s, EXP_MAX, 23'b0};
    lsbw = p + e - 23;
    if (lsbw < -149) lsbw = -149;
    sh = lsbw - e;
    if (sh <= 0) begin
      kept = mag << (-sh);
    end else begin
      if (sh >= 64) return {s, 31'b0};
      kept = mag >> sh;
      rem = mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    end
    if (kept[24]) begin
      kept = kept >> 1;
      lsbw++;
    end
    if (kept[23]) begin
      biased = lsbw + 150;
      if (biased >= 255) return {s, EXP_MAX, 23'b0};
      return {s, biased[7:0], kept[22:0]};
    end
    return {s, 8'h00, kept[22:0]};
  endfunction

  function automatic void split_f32(input logic [31:0] f, output logic s,
                                    output logic [63:0] m, output int e);
    s = f[31];
    if (f[30:23] == 0) begin
      m = {41'b0, f[22:0]};
      e = -149;
    end else begin
      m = {40'b0, 1'b1, f[22:0]};
      e = int'(f[30:23]) - 150;
    end
  endfunction

  function automatic logic is_nan(input logic [31:0] f);
    return f[30:23] == EXP_MAX && f[22:0] != 0;
  endfunction

  function automatic logic is_inf(input logic [31:0] f);
    return f[30:23] == EXP_MAX && f[22:0] == 0;
  endfunction

  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    if (h[14:10] == HALF_EXP_MAX) return {h[15], EXP_MAX, h[9:0], 13'b0};
    if (h[14:10] == 0) return round_f32(h[15], {54'b0, h[9:0]}, -24);
    return round_f32(h[15], {53'b0, 1'b1, h[9:0]}, int'(h[14:10]) - 25);
  endfunction

  function automatic logic [31:0] mul_f32(input logic [31:0] a, input logic [31:0] b);
    logic sa;
    logic sb;
    logic [63:0] ma;
    logic [63:0] mb;
    int ea;
    int eb;
    if (is_nan(a) || is_nan(b)) return CANON_NAN;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 0 || b[30:0] == 0) return CANON_NAN;
      return {a[31] ^ b[31], EXP_MAX, 23'b0};
    end
    split_f32(a, sa, ma, ea);
    split_f32(b, sb, mb, eb);
    return round_f32(sa ^ sb, ma * mb, ea + eb);
  endfunction

  function automatic logic [31:0] add_f32(input logic [31:0] a, input logic [31:0] b);
    logic sa;
    logic sb;
    logic st;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] mt;
    logic [63:0] big;
    logic [63:0] little;
    int ea;
    int eb;
    int et;
    int ex;
    if (is_nan(a) || is_nan(b)) return CANON_NAN;
    if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? CANON_NAN : a;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    split_f32(a, sa, ma, ea);
    split_f32(b, sb, mb, eb);
    if (ma == 0 && mb == 0) return {sa & sb, 31'b0};
    if (ma == 0) return b;
    if (mb == 0) return a;
    if (eb > ea) begin
      st = sa; mt = ma; et = ea;
      sa = sb; ma = mb; ea = eb;
      sb = st; mb = mt; eb = et;
    end
    if (ea - eb > 38) begin
      big = ma << 3;
      little = 64'd1;
      ex = ea - 3;
    end else begin
      big = ma << (ea - eb);
      little = mb;
      ex = eb;
    end
    if (sa == sb) return round_f32(sa, big + little, ex);
    if (big == little) return 32'h0;
    if (big > little) return round_f32(sa, big - little, ex);
    return round_f32(sb, little - big, ex);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [7:0] wbyte;
    logic signed [7:0] act0;
    logic signed [7:0] act1;
    logic signed [4:0] w0;
    logic signed [4:0] w1;
    logic [31:0] term;
    logic [31:0] scale;
    logic [16:0] acc_mag;
    if (!rst_n) begin
      block_sum = '0;
      pair_cnt = 0;
      row_sum = 32'h0;
      expected_dots.delete();
      errors = 0;
      dots_pending = 0;
      dots_seen = 0;
      blocks_closed = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        dots_seen++;
        if (expected_dots.size() == 0) begin
          report_mismatch($sformatf("unexpected row result %h", out_tdata));
        end else begin
          if (out_tdata !== expected_dots[0])
            report_mismatch($sformatf("dot_result %h, expected %h", out_tdata,
                                      expected_dots[0]));
          void'(expected_dots.pop_front());
        end
      end
      if (in_tvalid && in_tready) begin
        wbyte = in_tdata[7:0];
        act0 = in_tdata[15:8];
        act1 = in_tdata[23:16];
        w0 = $signed({1'b0, wbyte[3:0]}) - 5'sd8;
        w1 = $signed({1'b0, wbyte[7:4]}) - 5'sd8;
        block_sum = block_sum + w0 * act0 + w1 * act1;
        pair_cnt++;
        if (pair_cnt >= PAIRS_PER_BLOCK || in_tlast) begin
          blocks_closed++;
          scale = mul_f32(half_to_f32(in_tdata[39:24]), half_to_f32(in_tdata[55:40]));
          acc_mag = block_sum[ACC_W-1] ? -block_sum : block_sum;
          term = mul_f32(scale, round_f32(block_sum[ACC_W-1], {47'b0, acc_mag}, 0));
          row_sum = add_f32(row_sum, term);
          if (is_nan(row_sum)) row_sum = CANON_NAN;
          block_sum = '0;
          pair_cnt = 0;
        end
        if (in_tlast) begin
          expected_dots.push_back(row_sum);
          row_sum = 32'h0;
        end
      end
      dots_pending = expected_dots.size();
    end
  end

endmodule

FILE: verif/tb_quant4_block_dot_product.sv
// ----------------------------------------------------------------------------
// tb_quant4_block_dot_product: stimulus and verdict for the q4 dot product
// Drives directed rows covering weight and activation extremes, short and full
// blocks and special f16 scales, then random rows, with random idling on both
// stream sides. The checker predicts and compares; this module decides.
// ----------------------------------------------------------------------------
module tb_quant4_block_dot_product;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_REQUESTS = 430;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  int          errors;
  int          dots_pending;
  int          dots_seen;
  int          blocks_closed;
  int          requests_sent;
  int          quiet_cycles;
  int          out_wait;
  logic        no_idle;

  quant4_block_dot_product uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  tb_quant4_block_dot_product_chk chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .errors(errors), .dots_pending(dots_pending), .dots_seen(dots_seen),
    .blocks_closed(blocks_closed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_wait <= 0;
      out_tready <= 1'b1;
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      if (out_wait == 1) out_tready <= 1'b1;
    end else if (out_tvalid && out_tready) begin
      automatic int stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_tready <= 1'b0;
        out_wait <= stall;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_quant4_block_dot_product: errors");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [7:0] wbyte, input logic [7:0] act0,
                              input logic [7:0] act1, input logic [15:0] wscale,
                              input logic [15:0] ascale, input logic eor);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {ascale, wscale, act1, act0, wbyte};
    in_tlast <= eor;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  function automatic logic [15:0] pick_half();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return {1'($urandom), 5'($urandom_range(6, 22)), 10'($urandom)};
  endfunction

  initial begin
    int row_len;
    int r;
    int limit_wait;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    no_idle = 1'b0;
    requests_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_request(8'h00, 8'h80, 8'h80, 16'h3C00, 16'h3C00, 1'b1);
    send_request(8'hFF, 8'h7F, 8'h7F, 16'h7BFF, 16'h7BFF, 1'b1);
    send_request(8'h0F, 8'h80, 8'h7F, 16'h0001, 16'h0001, 1'b1);
    send_request(8'hF0, 8'h7F, 8'h80, 16'h03FF, 16'h8400, 1'b1);
    send_request(8'h88, 8'h55, 8'hAA, 16'h8000, 16'h3C00, 1'b1);
    send_request(8'h37, 8'h12, 8'hF3, 16'h7C00, 16'h3C00, 1'b1);
    send_request(8'h88, 8'h12, 8'hF3, 16'h7C00, 16'h3C00, 1'b1);
    send_request(8'h19, 8'h40, 8'hC0, 16'hFC00, 16'h7E00, 1'b1);
    send_request(8'h5A, 8'h21, 8'h9C, 16'h3555, 16'hC200, 1'b0);
    send_request(8'hA5, 8'h7E, 8'h01, 16'h4000, 16'h2000, 1'b1);
    for (int i = 0; i < 16; i++)
      send_request(8'hFF, 8'h7F, 8'h7F, (i == 15) ? 16'h3C00 : 16'h7C01, 16'h3800, 1'b0);
    send_request(8'h00, 8'h80, 8'h80, 16'h7BFF, 16'hFBFF, 1'b1);

    r = 0;
    while (r < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 3) == 0) no_idle = ~no_idle;
      row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
      for (int k = 1; k <= row_len; k++) begin
        send_request(8'($urandom), 8'($urandom), 8'($urandom), pick_half(), pick_half(),
                     k == row_len);
        r++;
      end
    end

    @(posedge clk);
    in_tvalid <= 1'b0;
    in_tlast <= 1'b0;
    while (dots_pending != 0) @(posedge clk);
    limit_wait = 0;
    while (limit_wait < 40) begin
      @(posedge clk);
      limit_wait++;
    end
    $display("Sent %0d requests, closing %0d blocks; checked %0d row results.",
             requests_sent, blocks_closed, dots_seen);
    $display("Stimulus covered weight and activation extremes, short and full blocks,");
    $display("and f16 subnormal, infinite and NaN scales.");
    if (errors == 0) begin
      $display("tb_quant4_block_dot_product: clean");
    end else begin
      $display("tb_quant4_block_dot_product: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/q4dp_pkg.sv
rtl/q4dp_ctrl.sv
rtl/q4dp_dpath.sv
rtl/quant4_block_dot_product.sv
verif/tb_quant4_block_dot_product_chk.sv
verif/tb_quant4_block_dot_product.sv
